>>> rtl/ufcb_pkg.sv
// Package: types, codes and widths for the upwind face coefficient blend.
package ufcb_pkg;

  // Width of one signed fixed-point value and of the minimum width register.
  localparam int unsigned ValW = 32;
  localparam int unsigned MinW = 31;

  // Codes for the case taken on a face.
  localparam logic [1:0] CASE_UPWIND_A = 2'd0;
  localparam logic [1:0] CASE_UPWIND_B = 2'd1;
  localparam logic [1:0] CASE_BLEND    = 2'd2;
  localparam logic [1:0] CASE_PRIOR    = 2'd3;

  // Input item of one face.
  typedef struct packed {
    logic                   interior_face;
    logic                   has_face_potential;
    logic signed [ValW-1:0] potential_a;
    logic signed [ValW-1:0] potential_b;
    logic signed [ValW-1:0] overlap_a;
    logic signed [ValW-1:0] overlap_b;
    logic signed [ValW-1:0] coef_a;
    logic signed [ValW-1:0] coef_b;
    logic signed [ValW-1:0] prior_coef;
  } ufcb_in_t;

  // Result item of one face.
  typedef struct packed {
    logic signed [ValW-1:0] face_coefficient;
    logic [1:0]             case_taken;
  } ufcb_out_t;

  // Data that rides along the width divider.
  typedef struct packed {
    logic                   interior;
    logic signed [ValW:0]   pdiff;
    logic signed [ValW-1:0] coef_a;
    logic signed [ValW-1:0] coef_b;
    logic signed [ValW-1:0] bnd_res;
    logic [1:0]             bnd_case;
  } ufcb_side1_t;

  // Data that rides along the blend divider.
  typedef struct packed {
    logic                   blend;
    logic                   neg;
    logic signed [ValW-1:0] coef_a;
    logic signed [ValW-1:0] res_direct;
    logic [1:0]             case_taken;
  } ufcb_side2_t;

endpackage

>>> rtl/upwind_face_coefficient_blend_top.sv
// Top level of the upwind face coefficient blend pipeline.
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+------------------------
//   in        | input     | in_valid_i/in_ready_o | in_data_i (ufcb_in_t)
//   out       | output    | out_valid_o/out_ready_i | out_data_o (ufcb_out_t)
//   cfg       | input     | cfg_we_i              | cfg_wdata_i (min width)
//
// One face transfer per cycle while no result waits at the output.
// The two dividers (width and blend weight) each resolve one quotient bit
// per pipeline stage.
// Reset clears all valid bits and sets the minimum width to one.
// When a result waits at the output, the whole pipeline holds and
// in_ready_o is low; no item is lost or repeated.
module upwind_face_coefficient_blend_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  ufcb_pkg::ufcb_in_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ufcb_pkg::ufcb_out_t      out_data_o,
  input  logic                     cfg_we_i,
  input  logic [ufcb_pkg::MinW-1:0] cfg_wdata_i
);

  localparam int unsigned VW = ufcb_pkg::ValW;
  localparam int unsigned MW = ufcb_pkg::MinW;

  logic          adv;
  logic [MW-1:0] minw_q;
  logic [MW-1:0] minw_eff;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minw_q <= MW'(1);
    end else if (cfg_we_i) begin
      minw_q <= cfg_wdata_i;
    end
  end

  assign minw_eff = (minw_q == '0) ? MW'(1) : minw_q;

  // The pipeline moves whenever the output register is free or drained.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- Stage 1: clamp, product, sum, boundary test
  logic [MW-1:0]           a0, a1;
  logic                    s1_vld_q;
  logic [2*MW-1:0]         s1_prod_q;
  logic [VW-1:0]           s1_sum_q;
  ufcb_pkg::ufcb_side1_t   s1_side_d, s1_side_q;

  always_comb begin
    a0 = in_data_i.overlap_a[VW-1] ? '0 : in_data_i.overlap_a[MW-1:0];
    a1 = in_data_i.overlap_b[VW-1] ? '0 : in_data_i.overlap_b[MW-1:0];
    s1_side_d.interior = in_data_i.interior_face;
    s1_side_d.pdiff    = {in_data_i.potential_b[VW-1], in_data_i.potential_b}
                       - {in_data_i.potential_a[VW-1], in_data_i.potential_a};
    s1_side_d.coef_a   = in_data_i.coef_a;
    s1_side_d.coef_b   = in_data_i.coef_b;
    if (!in_data_i.has_face_potential ||
        (in_data_i.potential_a >= in_data_i.potential_b)) begin
      s1_side_d.bnd_res  = in_data_i.coef_a;
      s1_side_d.bnd_case = ufcb_pkg::CASE_UPWIND_A;
    end else begin
      s1_side_d.bnd_res  = in_data_i.prior_coef;
      s1_side_d.bnd_case = ufcb_pkg::CASE_PRIOR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q <= (2*MW)'(a0) * (2*MW)'(a1);
      s1_sum_q  <= VW'(a0) + VW'(a1);
      s1_side_q <= s1_side_d;
    end
  end

  // ---------------- Width divider: w = a0*a1/(a0+a1)
  logic                  d1_vld;
  logic [MW-1:0]         d1_quot;
  logic [VW-1:0]         d1_den;
  logic [VW+MW-1:0]      d1_num;
  ufcb_pkg::ufcb_side1_t d1_side;

  // Both widths zero gives a zero width.
  assign d1_den = (s1_sum_q == '0) ? VW'(1) : s1_sum_q;
  assign d1_num = (s1_sum_q == '0) ? '0 : (VW+MW)'(s1_prod_q);

  ufcb_pipe_div #(
    .DEN_W  (VW),
    .Q_W    (MW),
    .SIDE_W ($bits(ufcb_pkg::ufcb_side1_t))
  ) u_wdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s1_vld_q),
    .num_i   (d1_num),
    .den_i   (d1_den),
    .side_i  (s1_side_q),
    .valid_o (d1_vld),
    .quot_o  (d1_quot),
    .side_o  (d1_side)
  );

  // ---------------- Stage 2: floor width, upwind tests, blend terms
  logic [MW-1:0]          w;
  logic signed [VW+1:0]   wx, dx, nx;
  logic signed [VW:0]     cdiff;
  logic                   up_a, up_b, half;
  logic                   s2_vld_q;
  logic [VW-1:0]          s2_mag_d, s2_mag_q, s2_num_d, s2_num_q, s2_den_d, s2_den_q;
  ufcb_pkg::ufcb_side2_t  s2_side_d, s2_side_q;

  always_comb begin
    w     = (d1_quot < minw_eff) ? minw_eff : d1_quot;
    wx    = $signed({3'b000, w});
    dx    = {d1_side.pdiff[VW], d1_side.pdiff};
    nx    = dx + wx;
    up_a  = (-dx > wx);
    up_b  = (dx > wx);
    half  = ({1'b0, w} < {minw_eff, 1'b0});
    cdiff = {d1_side.coef_b[VW-1], d1_side.coef_b}
          - {d1_side.coef_a[VW-1], d1_side.coef_a};
    s2_mag_d = cdiff[VW] ? VW'(-cdiff) : cdiff[VW-1:0];
    s2_num_d = half ? VW'(1) : nx[VW-1:0];
    s2_den_d = half ? VW'(2) : {w, 1'b0};
    s2_side_d.blend  = d1_side.interior && !up_a && !up_b;
    s2_side_d.neg    = cdiff[VW];
    s2_side_d.coef_a = d1_side.coef_a;
    if (!d1_side.interior) begin
      s2_side_d.res_direct = d1_side.bnd_res;
      s2_side_d.case_taken = d1_side.bnd_case;
    end else if (up_a) begin
      s2_side_d.res_direct = d1_side.coef_a;
      s2_side_d.case_taken = ufcb_pkg::CASE_UPWIND_A;
    end else if (up_b) begin
      s2_side_d.res_direct = d1_side.coef_b;
      s2_side_d.case_taken = ufcb_pkg::CASE_UPWIND_B;
    end else begin
      s2_side_d.res_direct = d1_side.coef_a;
      s2_side_d.case_taken = ufcb_pkg::CASE_BLEND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_mag_q  <= s2_mag_d;
      s2_num_q  <= s2_num_d;
      s2_den_q  <= s2_den_d;
      s2_side_q <= s2_side_d;
    end
  end

  // ---------------- Stage 3: scaled numerator with rounding bias
  logic                  s3_vld_q;
  logic [2*VW-1:0]       s3_num_q;
  logic [VW-1:0]         s3_den_q;
  ufcb_pkg::ufcb_side2_t s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_num_q  <= (2*VW)'(s2_mag_q) * (2*VW)'(s2_num_q)
                 + (2*VW)'(s2_den_q >> 1);
      s3_den_q  <= s2_den_q;
      s3_side_q <= s2_side_q;
    end
  end

  // ---------------- Blend divider: rounded |cb-ca|*n/d
  logic                  d2_vld;
  logic [VW-1:0]         d2_quot;
  ufcb_pkg::ufcb_side2_t d2_side;

  ufcb_pipe_div #(
    .DEN_W  (VW),
    .Q_W    (VW),
    .SIDE_W ($bits(ufcb_pkg::ufcb_side2_t))
  ) u_bdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_vld_q),
    .num_i   (s3_num_q),
    .den_i   (s3_den_q),
    .side_i  (s3_side_q),
    .valid_o (d2_vld),
    .quot_o  (d2_quot),
    .side_o  (d2_side)
  );

  // ---------------- Output stage: apply blend step and saturate
  logic signed [VW+1:0]  ca_x, q_x, res_wide;
  logic signed [VW-1:0]  res_sat;
  logic                  out_vld_q;
  ufcb_pkg::ufcb_out_t   out_d, out_q;

  localparam logic signed [VW+1:0] ResMax = (VW+2)'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [VW+1:0] ResMin = -ResMax - (VW+2)'(1);

  always_comb begin
    ca_x     = {{2{d2_side.coef_a[VW-1]}}, d2_side.coef_a};
    q_x      = $signed({2'b00, d2_quot});
    res_wide = d2_side.neg ? (ca_x - q_x) : (ca_x + q_x);
    if (res_wide > ResMax) begin
      res_sat = ResMax[VW-1:0];
    end else if (res_wide < ResMin) begin
      res_sat = ResMin[VW-1:0];
    end else begin
      res_sat = res_wide[VW-1:0];
    end
    out_d.face_coefficient = d2_side.blend ? res_sat : d2_side.res_direct;
    out_d.case_taken       = d2_side.case_taken;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // The blend weight numerator never exceeds its divisor.
  a_blend_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_side_q.blend) |-> (s2_num_q <= s2_den_q))
    else $error("blend weight above one");

  // A blended result always lies in range, so saturation stays idle.
  a_blend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d2_vld && d2_side.blend) |-> ((res_wide <= ResMax) && (res_wide >= ResMin)))
    else $error("blended result out of range");

  // A result that waits at the output is held valid and unchanged.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(out_q)))
    else $error("held result changed");

  // A blended face always carries the blend case code.
  a_blend_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_side_q.blend) |-> (s2_side_q.case_taken == ufcb_pkg::CASE_BLEND))
    else $error("blend flag and case code disagree");
`endif

endmodule

>>> rtl/ufcb_pipe_div.sv
// Pipelined restoring divider that resolves one quotient bit per stage.
module ufcb_pipe_div #(
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned Q_W    = 32,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [DEN_W+Q_W-1:0]   num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [Q_W-1:0]         quot_o,
  output logic [SIDE_W-1:0]      side_o
);

  // Stage 0 is the input; stage k holds the state after k quotient bits.
  logic              vld  [0:Q_W];
  logic [DEN_W-1:0]  rem  [0:Q_W];
  logic [Q_W-1:0]    lq   [0:Q_W];
  logic [DEN_W-1:0]  den  [0:Q_W];
  logic [SIDE_W-1:0] side [0:Q_W];

  // The upper numerator bits are already below the divisor.
  assign vld[0]  = valid_i;
  assign rem[0]  = num_i[DEN_W+Q_W-1:Q_W];
  assign lq[0]   = num_i[Q_W-1:0];
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] sub;
    logic           ge;

    // Shift in the next numerator bit and try to subtract the divisor.
    always_comb begin
      trial = {rem[k], lq[k][Q_W-1]};
      sub   = trial - {1'b0, den[k]};
      ge    = (trial >= {1'b0, den[k]});
    end

    // Valid bit of this stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    // Partial remainder, quotient bits and carried data.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[k+1]  <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
        lq[k+1]   <= {lq[k][Q_W-2:0], ge};
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign valid_o = vld[Q_W];
  assign quot_o  = lq[Q_W];
  assign side_o  = side[Q_W];

endmodule
